### hw/rtl/ssclk_pkg.sv
// Package for the serially set clock with gas alarms.
// Holds the request codes, field selectors, widths and the queue entry type.
// No dependencies.
package ssclk_pkg;

    // Fixed widths of the request fields
    localparam int KIND_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int PPM_W   = 16;
    localparam int TIME_W  = 8;
    localparam int MILLI_W = 10;

    // Millisecond ticks that make one second (1 to 1023)
    localparam logic [MILLI_W-1:0] TICKS_PER_SECOND = MILLI_W'(1000);

    // Wrap points of the time counters
    localparam logic [TIME_W-1:0] SECONDS_WRAP = TIME_W'(60);
    localparam logic [TIME_W-1:0] MINUTES_WRAP = TIME_W'(60);
    localparam logic [TIME_W-1:0] HOURS_WRAP   = TIME_W'(24);

    // Threshold values after reset
    localparam logic [PPM_W-1:0] LIMIT_A_RESET = PPM_W'(100);
    localparam logic [PPM_W-1:0] LIMIT_B_RESET = PPM_W'(5000);
    localparam logic [PPM_W-1:0] LIMIT_C_RESET = PPM_W'(5000);

    // Request kinds on the input channel
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd2;

    // Field selector bytes
    localparam logic [BYTE_W-1:0] SEL_HOUR    = 8'h68; // 'h'
    localparam logic [BYTE_W-1:0] SEL_MINUTE  = 8'h6D; // 'm'
    localparam logic [BYTE_W-1:0] SEL_SECOND  = 8'h73; // 's'
    localparam logic [BYTE_W-1:0] SEL_LIMIT_B = 8'h32; // '2'
    localparam logic [BYTE_W-1:0] SEL_LIMIT_C = 8'h33; // '3'
    localparam logic [BYTE_W-1:0] SEL_LIMIT_A = 8'h35; // '5'

    // Selected field codes
    localparam int FIELD_W = 3;
    localparam logic [FIELD_W-1:0] FLD_NONE    = 3'd0;
    localparam logic [FIELD_W-1:0] FLD_HOUR    = 3'd1;
    localparam logic [FIELD_W-1:0] FLD_MINUTE  = 3'd2;
    localparam logic [FIELD_W-1:0] FLD_SECOND  = 3'd3;
    localparam logic [FIELD_W-1:0] FLD_LIMIT_B = 3'd4;
    localparam logic [FIELD_W-1:0] FLD_LIMIT_C = 3'd5;
    localparam logic [FIELD_W-1:0] FLD_LIMIT_A = 3'd6;

    // Commands passed from the front to the back
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd3;

    // Command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Requests in flight at most: queue plus the output register
    localparam int PEND_W = $clog2(QUEUE_DEPTH + 2);

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [FIELD_W-1:0] field;
        logic               high;
        logic [BYTE_W-1:0]  data;
        logic [PPM_W-1:0]   gas_a;
        logic [PPM_W-1:0]   gas_b;
        logic [PPM_W-1:0]   gas_c;
    } cmd_t;

endpackage

### hw/rtl/ssclk_front.sv
// Front part: accepts requests, runs the serial field parser, emits commands.
// Depends on ssclk_pkg.
module ssclk_front
    import ssclk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [KIND_W-1:0] kind,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [PPM_W-1:0]  gas_a_ppm,
    input  logic [PPM_W-1:0]  gas_b_ppm,
    input  logic [PPM_W-1:0]  gas_c_ppm,
    input  logic              q_full,
    output logic              q_push,
    output cmd_t              q_data
);

    logic [FIELD_W-1:0] target_reg;
    logic [FIELD_W-1:0] target_next;
    logic               second_due_reg;
    logic               second_due_next;

    // Hold off the sender while the queue has no room
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // Classify the request and step the parser
    always_comb
    begin
        target_next     = target_reg;
        second_due_next = second_due_reg;
        q_data.cmd      = CMD_NONE;
        q_data.field    = target_reg;
        q_data.high     = second_due_reg;
        q_data.data     = rx_byte;
        q_data.gas_a    = gas_a_ppm;
        q_data.gas_b    = gas_b_ppm;
        q_data.gas_c    = gas_c_ppm;
        unique case (kind)
            KIND_TICK:   q_data.cmd = CMD_TICK;
            KIND_SAMPLE: q_data.cmd = CMD_SAMPLE;
            KIND_BYTE:
            begin
                if (target_reg == FLD_NONE)
                begin
                    // Select a field; unknown bytes drop
                    unique case (rx_byte)
                        SEL_HOUR:    target_next = FLD_HOUR;
                        SEL_MINUTE:  target_next = FLD_MINUTE;
                        SEL_SECOND:  target_next = FLD_SECOND;
                        SEL_LIMIT_B: target_next = FLD_LIMIT_B;
                        SEL_LIMIT_C: target_next = FLD_LIMIT_C;
                        SEL_LIMIT_A: target_next = FLD_LIMIT_A;
                        default:     target_next = FLD_NONE;
                    endcase
                end
                else if (target_reg > FLD_LIMIT_A)
                begin
                    // Recover from an unused selector code
                    target_next     = FLD_NONE;
                    second_due_next = 1'b0;
                end
                else
                begin
                    q_data.cmd = CMD_WRITE;
                    if (second_due_reg)
                    begin
                        target_next     = FLD_NONE;
                        second_due_next = 1'b0;
                    end
                    else
                    begin
                        second_due_next = 1'b1;
                    end
                end
            end
            default: q_data.cmd = CMD_NONE;
        endcase
    end

    // Advance the parser on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= FLD_NONE;
            second_due_reg <= 1'b0;
        end
        else if (q_push)
        begin
            target_reg     <= target_next;
            second_due_reg <= second_due_next;
        end
    end

endmodule

### hw/rtl/ssclk_queue.sv
// Short command queue between the front and the back.
// Depends on ssclk_pkg.
module ssclk_queue
    import ssclk_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    // Track the fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            end
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/ssclk_back.sv
// Back part: carries out commands on the clock and thresholds, holds the result.
// Depends on ssclk_pkg.
module ssclk_back
    import ssclk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_not_empty,
    input  cmd_t              q_head,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [TIME_W-1:0] hour_now,
    output logic [TIME_W-1:0] minute_now,
    output logic [TIME_W-1:0] second_now,
    output logic              alarm_a,
    output logic              alarm_b,
    output logic              alarm_c
);

    logic [MILLI_W-1:0] milli_reg;
    logic [MILLI_W-1:0] milli_next;
    logic [TIME_W-1:0]  seconds_reg;
    logic [TIME_W-1:0]  seconds_next;
    logic [TIME_W-1:0]  minutes_reg;
    logic [TIME_W-1:0]  minutes_next;
    logic [TIME_W-1:0]  hours_reg;
    logic [TIME_W-1:0]  hours_next;
    logic [PPM_W-1:0]   limit_a_reg;
    logic [PPM_W-1:0]   limit_a_next;
    logic [PPM_W-1:0]   limit_b_reg;
    logic [PPM_W-1:0]   limit_b_next;
    logic [PPM_W-1:0]   limit_c_reg;
    logic [PPM_W-1:0]   limit_c_next;
    logic [2:0]         alarm_reg;
    logic [2:0]         alarm_next;
    logic               out_valid_reg;
    logic [MILLI_W-1:0] milli_inc;
    logic [TIME_W-1:0]  sec_inc;
    logic [TIME_W-1:0]  min_inc;
    logic [TIME_W-1:0]  hour_inc;

    // Take the next command once the result slot is free or being taken
    assign q_pop = q_not_empty && (!out_valid_reg || !out_stall);

    // Time and alarms hold while the result waits
    assign out_valid  = out_valid_reg;
    assign hour_now   = hours_reg;
    assign minute_now = minutes_reg;
    assign second_now = seconds_reg;
    assign alarm_a    = alarm_reg[0];
    assign alarm_b    = alarm_reg[1];
    assign alarm_c    = alarm_reg[2];

    assign milli_inc = milli_reg + 1'b1;
    assign sec_inc   = seconds_reg + 1'b1;
    assign min_inc   = minutes_reg + 1'b1;
    assign hour_inc  = hours_reg + 1'b1;

    // Execute one command
    always_comb
    begin
        milli_next   = milli_reg;
        seconds_next = seconds_reg;
        minutes_next = minutes_reg;
        hours_next   = hours_reg;
        limit_a_next = limit_a_reg;
        limit_b_next = limit_b_reg;
        limit_c_next = limit_c_reg;
        alarm_next   = 3'b000;
        case (q_head.cmd)
            CMD_TICK:
            begin
                milli_next = milli_inc;
                if (milli_inc == TICKS_PER_SECOND)
                begin
                    milli_next   = '0;
                    seconds_next = sec_inc;
                    if (sec_inc == SECONDS_WRAP)
                    begin
                        seconds_next = '0;
                        minutes_next = min_inc;
                        if (min_inc == MINUTES_WRAP)
                        begin
                            minutes_next = '0;
                            hours_next   = (hour_inc == HOURS_WRAP) ? '0 : hour_inc;
                        end
                    end
                end
            end
            CMD_WRITE:
            begin
                unique case (q_head.field)
                    FLD_HOUR:
                    begin
                        if (!q_head.high)
                        begin
                            hours_next = q_head.data;
                        end
                    end
                    FLD_MINUTE:
                    begin
                        if (!q_head.high)
                        begin
                            minutes_next = q_head.data;
                        end
                    end
                    FLD_SECOND:
                    begin
                        if (!q_head.high)
                        begin
                            seconds_next = q_head.data;
                        end
                    end
                    FLD_LIMIT_B:
                    begin
                        limit_b_next = q_head.high ? {q_head.data, limit_b_reg[7:0]}
                                                   : {8'h00, q_head.data};
                    end
                    FLD_LIMIT_C:
                    begin
                        limit_c_next = q_head.high ? {q_head.data, limit_c_reg[7:0]}
                                                   : {8'h00, q_head.data};
                    end
                    FLD_LIMIT_A:
                    begin
                        limit_a_next = q_head.high ? {q_head.data, limit_a_reg[7:0]}
                                                   : {8'h00, q_head.data};
                    end
                    default:
                    begin
                        limit_a_next = limit_a_reg;
                    end
                endcase
            end
            CMD_SAMPLE:
            begin
                alarm_next[0] = (q_head.gas_a > limit_a_reg);
                alarm_next[1] = (q_head.gas_b > limit_b_reg);
                alarm_next[2] = (q_head.gas_c > limit_c_reg);
            end
            default:
            begin
                alarm_next = 3'b000;
            end
        endcase
    end

    // Update state and the result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            milli_reg     <= '0;
            seconds_reg   <= '0;
            minutes_reg   <= '0;
            hours_reg     <= '0;
            limit_a_reg   <= LIMIT_A_RESET;
            limit_b_reg   <= LIMIT_B_RESET;
            limit_c_reg   <= LIMIT_C_RESET;
            alarm_reg     <= 3'b000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                milli_reg     <= milli_next;
                seconds_reg   <= seconds_next;
                minutes_reg   <= minutes_next;
                hours_reg     <= hours_next;
                limit_a_reg   <= limit_a_next;
                limit_b_reg   <= limit_b_next;
                limit_c_reg   <= limit_c_next;
                alarm_reg     <= alarm_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### hw/rtl/serial_set_clock_with_gas_alarms.sv
// Top level of the serially set clock with gas alarms.
// Depends on ssclk_pkg, ssclk_front, ssclk_queue and ssclk_back.
//
// Each input request is a millisecond tick, a received serial byte or a set of
// three gas readings, and yields exactly one result: the time of day after the
// request and, for a reading set, one alarm flag per gas that is above its
// threshold. Serial bytes select a field ('h', 'm', 's', '2', '3', '5') and then
// write a low and a high byte to it. The block takes one request per clock cycle
// while the queue has room: the front decodes each request into a four-entry
// command queue, and the back takes one command at a time, updates the clock
// and thresholds and registers the result into the output slot. A stalled
// output lets up to four more requests queue before in_stall rises.
module serial_set_clock_with_gas_alarms
    import ssclk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [KIND_W-1:0] kind,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [PPM_W-1:0]  gas_a_ppm,
    input  logic [PPM_W-1:0]  gas_b_ppm,
    input  logic [PPM_W-1:0]  gas_c_ppm,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [TIME_W-1:0] hour_now,
    output logic [TIME_W-1:0] minute_now,
    output logic [TIME_W-1:0] second_now,
    output logic              alarm_a,
    output logic              alarm_b,
    output logic              alarm_c
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_not_empty;
    cmd_t q_data;
    cmd_t q_head;

    // Accept and decode requests
    ssclk_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .rx_byte   (rx_byte),
        .gas_a_ppm (gas_a_ppm),
        .gas_b_ppm (gas_b_ppm),
        .gas_c_ppm (gas_c_ppm),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    // Buffer commands
    ssclk_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // Execute commands and present results
    ssclk_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hour_now    (hour_now),
        .minute_now  (minute_now),
        .second_now  (second_now),
        .alarm_a     (alarm_a),
        .alarm_b     (alarm_b),
        .alarm_c     (alarm_c)
    );

endmodule

### hw/rtl/ssclk_checker.sv
// Port-level checker for the serially set clock with gas alarms, with its bind.
// Depends on ssclk_pkg and serial_set_clock_with_gas_alarms.
module ssclk_checker
    import ssclk_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [TIME_W-1:0] hour_now,
    input logic [TIME_W-1:0] minute_now,
    input logic [TIME_W-1:0] second_now,
    input logic              alarm_a,
    input logic              alarm_b,
    input logic              alarm_c
);

    logic [PEND_W-1:0] pending_reg;
    logic              in_take;
    logic              out_take;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    // Count requests whose result is not yet taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_take && !out_take)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (out_take && !in_take)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    // No result without an outstanding request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != '0))
        else $error("result shown with no outstanding request");

    // An empty block never stalls the sender
    assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == '0) |-> !in_stall)
        else $error("input stalled while block is empty");

    // A stalled result stays shown
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped under stall");

    // A stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(hour_now) && $stable(minute_now)
            && $stable(second_now) && $stable(alarm_a) && $stable(alarm_b)
            && $stable(alarm_c)))
        else $error("result changed under stall");

endmodule

bind serial_set_clock_with_gas_alarms ssclk_checker u_ssclk_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hour_now   (hour_now),
    .minute_now (minute_now),
    .second_now (second_now),
    .alarm_a    (alarm_a),
    .alarm_b    (alarm_b),
    .alarm_c    (alarm_c)
);
